// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker in ccb_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed: label");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== hdl/ccb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_pkg
// Types and constants shared by the cell charge and balance controller.
// ----------------------------------------------------------------------------
package ccb_pkg;

	localparam int CELL_COUNT = 4;

	typedef logic [12:0] cell_mv_t;
	typedef logic [14:0] pack_mv_t;
	typedef logic [14:0] timer_t;
	typedef logic [2:0]  cell_idx_t;
	typedef logic [CELL_COUNT-1:0] cell_mask_t;

	localparam cell_mv_t FULL_SCALE_MV = '1;
	localparam timer_t   TIMER_MAX     = '1;

	// Reset values of the configuration registers
	localparam cell_mv_t UNDER_VOLTAGE_RST = 13'd2600;
	localparam cell_mv_t OVER_VOLTAGE_RST  = 13'd4150;
	localparam pack_mv_t CHARGE_START_RST  = 15'd16000;
	localparam pack_mv_t CHARGE_STOP_RST   = 15'd16200;
	localparam cell_mv_t BLEED_MARGIN_RST  = 13'd10;
	localparam timer_t   SETTLE_MS_RST     = 15'd5000;
	localparam timer_t   BLEED_MS_RST      = 15'd20000;

	// Configuration register indexes
	typedef enum logic [3:0] {
		REG_UNDER_VOLTAGE = 4'd0,
		REG_OVER_VOLTAGE  = 4'd1,
		REG_CHARGE_START  = 4'd2,
		REG_CHARGE_STOP   = 4'd3,
		REG_BLEED_MARGIN  = 4'd4,
		REG_SETTLE_MS     = 4'd5,
		REG_BLEED_MS      = 4'd6,
		REG_BALANCING_ON  = 4'd7
	} cfg_reg_t;

	// Balancing sequencer states
	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_SETTLE   = 2'd1,
		MODE_BALANCE  = 2'd2
	} balance_mode_t;

	// Item kinds
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef struct packed {
		logic     func;
		cell_mv_t cell1_mv;
		cell_mv_t cell2_mv;
		cell_mv_t cell3_mv;
		cell_mv_t cell4_mv;
		logic [3:0] cells_valid;
		pack_mv_t pack_mv;
		logic     pack_valid;
	} sample_t;

	typedef struct packed {
		logic       charger_on;
		cell_idx_t  lowest_cell;
		cell_idx_t  highest_cell;
		cell_mv_t   spread_mv;
		logic [3:0] bleed_mask;
		logic [1:0] balance_mode;
	} result_t;

	// Extremes of one sample, handed from the statistics logic to the top
	typedef struct packed {
		cell_idx_t min_idx;
		cell_mv_t  min_mv;
		cell_idx_t max_idx;
		cell_mv_t  max_mv;
		cell_mv_t  spread_mv;
	} cell_stats_t;

endpackage

// ===== hdl/cell_charge_balance_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_charge_balance_controller
// Charge hysteresis and passive balancing sequencer for a four-cell pack.
// ----------------------------------------------------------------------------
// The block takes one request (a measurement sample or a millisecond tick)
// every clock cycle unless sample_stall is high, and returns one result per
// request, in order. A request lands in the sample register; from there the
// cell min/max scan, the charge hysteresis and the sequencer step are
// evaluated in one pass and written to the result register when the result
// register is empty or its result is being taken. A stalled result holds its
// register while one more request waits in the sample register; further
// requests are stalled until the result is taken. Configuration writes are
// always ready and are meant to be issued while no request is in flight.
module cell_charge_balance_controller (
	input  logic             clk,
	input  logic             arst_n,
	// sample channel
	input  logic             sample_valid,
	output logic             sample_stall,
	input  ccb_pkg::sample_t sample,
	// result channel
	output logic             result_valid,
	input  logic             result_stall,
	output ccb_pkg::result_t result,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [3:0]       cfg_index,
	input  logic [14:0]      cfg_data
);
	import ccb_pkg::*;

	// configuration registers
	cell_mv_t under_voltage_q, over_voltage_q, bleed_margin_q;
	pack_mv_t charge_start_q, charge_stop_q;
	timer_t   settle_ms_q, bleed_ms_q;
	logic     balancing_on_q;

	// controller state
	logic          charging_q;
	balance_mode_t mode_q;
	logic          phase_odd_q;
	cell_mask_t    mask_q;
	timer_t        settle_q, bleed_q;

	// pipeline
	sample_t sample_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;

	// combinational results
	cell_mv_t      cells [CELL_COUNT];
	cell_stats_t   stats;
	logic          is_tick, do_step;
	logic          settle_done, bleed_done;
	logic          charging_d, enable_d;
	balance_mode_t mode_d;
	cell_mask_t    mask_d, new_mask;
	logic          phase_odd_d;
	timer_t        settle_d, bleed_d;
	result_t       result_d;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			under_voltage_q <= UNDER_VOLTAGE_RST;
			over_voltage_q  <= OVER_VOLTAGE_RST;
			charge_start_q  <= CHARGE_START_RST;
			charge_stop_q   <= CHARGE_STOP_RST;
			bleed_margin_q  <= BLEED_MARGIN_RST;
			settle_ms_q     <= SETTLE_MS_RST;
			bleed_ms_q      <= BLEED_MS_RST;
			balancing_on_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_UNDER_VOLTAGE: under_voltage_q <= cfg_data[12:0];
				REG_OVER_VOLTAGE:  over_voltage_q  <= cfg_data[12:0];
				REG_CHARGE_START:  charge_start_q  <= cfg_data;
				REG_CHARGE_STOP:   charge_stop_q   <= cfg_data;
				REG_BLEED_MARGIN:  bleed_margin_q  <= cfg_data[12:0];
				REG_SETTLE_MS:     settle_ms_q     <= cfg_data;
				REG_BLEED_MS:      bleed_ms_q      <= cfg_data;
				REG_BALANCING_ON:  balancing_on_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hand-off between the sample register and the result register
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// Cell extremes
	assign cells[0] = sample_s1.cell1_mv;
	assign cells[1] = sample_s1.cell2_mv;
	assign cells[2] = sample_s1.cell3_mv;
	assign cells[3] = sample_s1.cell4_mv;

	ccb_stats u_stats (
		.cells       (cells),
		.cells_valid (sample_s1.cells_valid),
		.stats       (stats)
	);

	assign is_tick     = (sample_s1.func == FUNC_TICK);
	assign do_step     = !is_tick && balancing_on_q;
	assign settle_done = (settle_q >= settle_ms_q);
	assign bleed_done  = (bleed_q >= bleed_ms_q);

	// Charge hysteresis; an invalid pack reading holds the state and gates the output
	always_comb begin
		charging_d = charging_q;
		if (!is_tick && sample_s1.pack_valid) begin
			if (!charging_q) begin
				if (stats.max_mv < over_voltage_q && stats.min_mv > under_voltage_q &&
				    sample_s1.pack_mv < charge_start_q) begin
					charging_d = 1'b1;
				end
			end else begin
				if (stats.min_mv < under_voltage_q || stats.max_mv >= over_voltage_q ||
				    sample_s1.pack_mv >= charge_stop_q) begin
					charging_d = 1'b0;
				end
			end
		end
		enable_d = is_tick ? charging_q : (sample_s1.pack_valid && charging_d);
	end

	// Bleed mask for the current phase
	always_comb begin
		cell_mv_t excess;
		new_mask = '0;
		excess   = '0;
		for (int i = 0; i < CELL_COUNT; i++) begin
			excess = cell_mv_t'(cells[i] - stats.min_mv);
			if ((((i % 2) == 0) == phase_odd_q) && sample_s1.cells_valid[i] &&
			    stats.min_idx != cell_idx_t'(i + 1) && cells[i] > under_voltage_q &&
			    cells[i] >= stats.min_mv && excess >= bleed_margin_q) begin
				new_mask[i] = 1'b1;
			end
		end
	end

	// Sequencer next state
	always_comb begin
		mode_d = mode_q;
		if (do_step) begin
			case (mode_q)
				MODE_SETTLE:  if (settle_done) mode_d = MODE_BALANCE;
				MODE_BALANCE: if (bleed_done) mode_d = MODE_SETTLE;
				default:      mode_d = MODE_SETTLE;
			endcase
		end
	end

	// Sequencer outputs: mask, phase and timers
	always_comb begin
		mask_d      = mask_q;
		phase_odd_d = phase_odd_q;
		settle_d    = settle_q;
		bleed_d     = bleed_q;
		if (is_tick) begin
			if (settle_q != TIMER_MAX) settle_d = settle_q + timer_t'(1);
			if (bleed_q != TIMER_MAX) bleed_d = bleed_q + timer_t'(1);
		end else if (do_step) begin
			case (mode_q)
				MODE_SETTLE: begin
					if (settle_done) begin
						mask_d      = new_mask;
						phase_odd_d = !phase_odd_q;
						bleed_d     = '0;
					end
				end
				MODE_BALANCE: begin
					if (bleed_done) begin
						mask_d   = '0;
						settle_d = '0;
					end
				end
				default: settle_d = '0;
			endcase
		end
	end

	// Assemble the result
	always_comb begin
		result_d.charger_on    = enable_d;
		result_d.lowest_cell   = is_tick ? cell_idx_t'(0) : stats.min_idx;
		result_d.highest_cell  = is_tick ? cell_idx_t'(0) : stats.max_idx;
		result_d.spread_mv     = is_tick ? cell_mv_t'(0) : stats.spread_mv;
		result_d.bleed_mask    = mask_d;
		result_d.balance_mode  = mode_d;
	end

	// Commit state as the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charging_q  <= 1'b0;
			mode_q      <= MODE_DISABLED;
			phase_odd_q <= 1'b1;
			mask_q      <= '0;
			settle_q    <= '0;
			bleed_q     <= '0;
		end else if (advance) begin
			charging_q  <= charging_d;
			mode_q      <= mode_d;
			phase_odd_q <= phase_odd_d;
			mask_q      <= mask_d;
			settle_q    <= settle_d;
			bleed_q     <= bleed_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

endmodule

// ===== hdl/ccb_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_stats
// Finds the first strictly lowest and highest valid cell and their spread.
// ----------------------------------------------------------------------------
module ccb_stats (
	input  ccb_pkg::cell_mv_t    cells [ccb_pkg::CELL_COUNT],
	input  ccb_pkg::cell_mask_t  cells_valid,
	output ccb_pkg::cell_stats_t stats
);
	import ccb_pkg::*;

	// Scan cells in order; ties keep the earlier cell
	always_comb begin
		cell_idx_t min_idx;
		cell_mv_t  min_mv;
		cell_idx_t max_idx;
		cell_mv_t  max_mv;
		min_idx = '0;
		min_mv  = FULL_SCALE_MV;
		max_idx = '0;
		max_mv  = '0;
		for (int i = 0; i < CELL_COUNT; i++) begin
			if (cells_valid[i]) begin
				if (min_idx == '0 || cells[i] < min_mv) begin
					min_idx = cell_idx_t'(i + 1);
					min_mv  = cells[i];
				end
				if (cells[i] > max_mv) begin
					max_idx = cell_idx_t'(i + 1);
					max_mv  = cells[i];
				end
			end
		end
		stats.min_idx   = min_idx;
		stats.min_mv    = min_mv;
		stats.max_idx   = max_idx;
		stats.max_mv    = max_mv;
		stats.spread_mv = (min_idx != '0 && max_idx != '0) ? cell_mv_t'(max_mv - min_mv) : '0;
	end

endmodule

// ===== hdl/ccb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_checker
// Port-level checks on the result channel of the controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_stall,
	input ccb_pkg::result_t result
);
	import ccb_pkg::*;

	// A stalled result stays offered and unchanged
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))

	// Cells are bled only inside a balancing window
	`ASSERT_SAME(a_mask_in_window, clk, arst_n, result_valid && result.bleed_mask != '0, result.balance_mode == MODE_BALANCE)

	// No lowest cell means no highest cell and no spread
	`ASSERT_SAME(a_no_cells, clk, arst_n, result_valid && result.lowest_cell == '0, result.highest_cell == '0 && result.spread_mv == '0)

endmodule

bind cell_charge_balance_controller ccb_checker u_ccb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
